>>> hw/rtl/rpnsa_pkg.sv
// rpnsa_pkg: shared types and constants for the four-level rpn stack alu
// no dependencies; used by the interfaces, the alu, the top level and the checker

package rpnsa_pkg;

  // default configuration, handed down through the top level parameters
  localparam int unsigned STACK_DEPTH_DEF = 4;
  localparam int unsigned DATA_WIDTH_DEF  = 32;

  // fixed field widths of the channels
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned OP_W       = 8;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned OUT_LEVELS = 4;

  // item kinds
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_OPER = 1'b1;

  // operator bytes (ascii)
  localparam logic [OP_W-1:0] OP_PLUS   = 8'h2B;
  localparam logic [OP_W-1:0] OP_MINUS  = 8'h2D;
  localparam logic [OP_W-1:0] OP_TIMES  = 8'h2A;
  localparam logic [OP_W-1:0] OP_DIVIDE = 8'h2F;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_DIV0  = 2'd1,
    ST_BADOP = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef enum logic [2:0] {
    ALU_IDLE,
    ALU_NEG_N,
    ALU_NEG_D,
    ALU_MUL_RUN,
    ALU_DIV_RUN,
    ALU_FIX
  } alu_state_e;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_RUN,
    TOP_DONE
  } top_state_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

endpackage

>>> hw/rtl/rpnsa_in_if.sv
// rpnsa_in_if: input item channel (valid/ready plus push or operate payload)
// depends on rpnsa_pkg for field widths

interface rpnsa_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [rpnsa_pkg::VALUE_W-1:0] push_value;
  logic [rpnsa_pkg::OP_W-1:0]          op_char;

  modport source (output valid, kind, push_value, op_char, input ready);
  modport sink   (input valid, kind, push_value, op_char, output ready);
endinterface

>>> hw/rtl/rpnsa_out_if.sv
// rpnsa_out_if: result channel (valid/ready plus four stack levels and status)
// depends on rpnsa_pkg for field widths

interface rpnsa_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rpnsa_pkg::VALUE_W-1:0] level_x;
  logic signed [rpnsa_pkg::VALUE_W-1:0] level_y;
  logic signed [rpnsa_pkg::VALUE_W-1:0] level_z;
  logic signed [rpnsa_pkg::VALUE_W-1:0] level_t;
  logic [rpnsa_pkg::STATUS_W-1:0]       status;

  modport source (output valid, level_x, level_y, level_z, level_t, status, input ready);
  modport sink   (input valid, level_x, level_y, level_z, level_t, status, output ready);
endinterface

>>> hw/rtl/rpnsa_alu.sv
// rpnsa_alu: iterative integer alu around one shared adder
// add/sub in one pass, shift-add multiply and restoring signed divide bit by bit
// depends on rpnsa_pkg

module rpnsa_alu #(
  parameter int unsigned DATA_WIDTH = rpnsa_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rpnsa_pkg::alu_req_t   req_i,
  input  logic [DATA_WIDTH-1:0] opa_i,
  input  logic [DATA_WIDTH-1:0] opb_i,
  output logic                  done_o,
  output logic [DATA_WIDTH-1:0] result_o
);

  localparam int unsigned AW    = DATA_WIDTH + 2;
  localparam int unsigned CNT_W = $clog2(DATA_WIDTH);

  rpnsa_pkg::alu_state_e state_q, state_d;
  rpnsa_pkg::alu_op_e    op_q, op_d;
  logic [DATA_WIDTH-1:0] acc_q, acc_d;
  logic [DATA_WIDTH-1:0] dvs_q, dvs_d;   // multiplicand or divisor
  logic [DATA_WIDTH-1:0] shf_q, shf_d;   // multiplier or dividend, then quotient
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  neg_q, neg_d;
  logic                  done_q, done_d;

  logic [AW-1:0] add_a, add_b, add_sum;
  logic          add_sub;
  logic          qbit;

  // the one adder that every operation goes through
  assign add_sum = add_a + (add_sub ? ~add_b : add_b) + AW'(add_sub);
  assign qbit    = ~add_sum[AW-1];

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b1;
    unique case (state_q)
      rpnsa_pkg::ALU_IDLE: begin
        add_a   = {2'b00, opa_i};
        add_b   = {2'b00, opb_i};
        add_sub = (req_i.op == rpnsa_pkg::ALU_SUB);
      end
      rpnsa_pkg::ALU_NEG_N: add_b = {2'b00, shf_q};
      rpnsa_pkg::ALU_NEG_D: add_b = {2'b00, dvs_q};
      rpnsa_pkg::ALU_MUL_RUN: begin
        add_a   = {2'b00, acc_q};
        add_b   = shf_q[0] ? {2'b00, dvs_q} : '0;
        add_sub = 1'b0;
      end
      rpnsa_pkg::ALU_DIV_RUN: begin
        // trial subtract of the divisor from the partial remainder
        add_a = {1'b0, acc_q, shf_q[DATA_WIDTH-1]};
        add_b = {2'b00, dvs_q};
      end
      rpnsa_pkg::ALU_FIX: add_b = {2'b00, shf_q};
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    acc_d   = acc_q;
    dvs_d   = dvs_q;
    shf_d   = shf_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    unique case (state_q)
      rpnsa_pkg::ALU_IDLE: begin
        if (req_i.start) begin
          op_d  = req_i.op;
          cnt_d = CNT_W'(DATA_WIDTH - 1);
          unique case (req_i.op)
            rpnsa_pkg::ALU_ADD, rpnsa_pkg::ALU_SUB: begin
              acc_d  = add_sum[DATA_WIDTH-1:0];
              done_d = 1'b1;
            end
            rpnsa_pkg::ALU_MUL: begin
              acc_d   = '0;
              dvs_d   = opa_i;
              shf_d   = opb_i;
              state_d = rpnsa_pkg::ALU_MUL_RUN;
            end
            rpnsa_pkg::ALU_DIV: begin
              acc_d   = '0;
              shf_d   = opa_i;
              dvs_d   = opb_i;
              neg_d   = opa_i[DATA_WIDTH-1] ^ opb_i[DATA_WIDTH-1];
              state_d = rpnsa_pkg::ALU_NEG_N;
            end
            default: ;
          endcase
        end
      end
      rpnsa_pkg::ALU_NEG_N: begin
        if (shf_q[DATA_WIDTH-1]) shf_d = add_sum[DATA_WIDTH-1:0];
        state_d = rpnsa_pkg::ALU_NEG_D;
      end
      rpnsa_pkg::ALU_NEG_D: begin
        if (dvs_q[DATA_WIDTH-1]) dvs_d = add_sum[DATA_WIDTH-1:0];
        state_d = rpnsa_pkg::ALU_DIV_RUN;
      end
      rpnsa_pkg::ALU_MUL_RUN: begin
        acc_d = add_sum[DATA_WIDTH-1:0];
        dvs_d = {dvs_q[DATA_WIDTH-2:0], 1'b0};
        shf_d = {1'b0, shf_q[DATA_WIDTH-1:1]};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = rpnsa_pkg::ALU_IDLE;
        end
      end
      rpnsa_pkg::ALU_DIV_RUN: begin
        acc_d = qbit ? add_sum[DATA_WIDTH-1:0] : {acc_q[DATA_WIDTH-2:0], shf_q[DATA_WIDTH-1]};
        shf_d = {shf_q[DATA_WIDTH-2:0], qbit};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) state_d = rpnsa_pkg::ALU_FIX;
      end
      rpnsa_pkg::ALU_FIX: begin
        if (neg_q) shf_d = add_sum[DATA_WIDTH-1:0];
        done_d  = 1'b1;
        state_d = rpnsa_pkg::ALU_IDLE;
      end
      default: state_d = rpnsa_pkg::ALU_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpnsa_pkg::ALU_IDLE;
      op_q    <= rpnsa_pkg::ALU_ADD;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
      neg_q   <= neg_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    dvs_q <= dvs_d;
    shf_q <= shf_d;
  end

  assign done_o   = done_q;
  assign result_o = (op_q == rpnsa_pkg::ALU_DIV) ? shf_q : acc_q;

endmodule

>>> hw/rtl/rpn_four_level_stack_alu_unit.sv
// rpn_four_level_stack_alu_unit: rpn stack of signed words with an integer alu
// depends on rpnsa_pkg, rpnsa_in_if, rpnsa_out_if and rpnsa_alu
//
//   channel   dir  handshake     payload
//   in_ch_i   in   valid/ready   kind, push_value, op_char
//   out_ch_o  out  valid/ready   level_x, level_y, level_z, level_t, status
//
// one item at a time; in_ch_i.ready is high only while the sequencer is idle
// push and errors skip the alu; add/sub, multiply and divide wait in the run state for it
// multiply and divide go through the shared adder, one bit a cycle
// a finished result waits in the sequencer while the output register is still held
// asynchronous active-low reset clears the stack to zero and empties the output

module rpn_four_level_stack_alu_unit #(
  parameter int unsigned STACK_DEPTH = rpnsa_pkg::STACK_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH  = rpnsa_pkg::DATA_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rpnsa_in_if.sink      in_ch_i,
  rpnsa_out_if.source   out_ch_o
);

  localparam int unsigned VW = rpnsa_pkg::VALUE_W;
  localparam int unsigned NL = rpnsa_pkg::OUT_LEVELS;

  rpnsa_pkg::top_state_e state_q, state_d;
  rpnsa_pkg::status_e    status_q, status_d;
  rpnsa_pkg::status_e    out_status_q;
  rpnsa_pkg::alu_req_t   alu_req;

  logic                  kind_q, kind_d;
  logic                  apply_q, apply_d;
  logic [DATA_WIDTH-1:0] push_q, push_d;
  logic [DATA_WIDTH-1:0] push_ext;
  logic [DATA_WIDTH-1:0] stk_q [STACK_DEPTH];
  logic [DATA_WIDTH-1:0] stk_d [STACK_DEPTH];
  logic [VW-1:0]         lvl_fit [NL];
  logic [VW-1:0]         out_lvl_q [NL];
  logic                  out_valid_q;
  logic                  alu_done;
  logic [DATA_WIDTH-1:0] alu_res;
  logic                  in_ready, in_fire, out_free, commit;

  assign in_ready = (state_q == rpnsa_pkg::TOP_IDLE);
  assign in_fire  = in_ch_i.valid && in_ready;
  assign out_free = !out_valid_q || out_ch_o.ready;
  assign commit   = (state_q == rpnsa_pkg::TOP_DONE) && out_free;

  // sign-extend the 32-bit push value to a wider word, or cut it to a narrower one
  if (DATA_WIDTH <= VW) begin : g_push_cut
    assign push_ext = in_ch_i.push_value[DATA_WIDTH-1:0];
  end else begin : g_push_ext
    assign push_ext = {{(DATA_WIDTH-VW){in_ch_i.push_value[VW-1]}}, in_ch_i.push_value};
  end

  rpnsa_alu #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (alu_req),
    .opa_i   (stk_q[1]),
    .opb_i   (stk_q[0]),
    .done_o  (alu_done),
    .result_o(alu_res)
  );

  // sequencer: decode, run the alu, wait for the output slot
  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    apply_d  = apply_q;
    kind_d   = kind_q;
    push_d   = push_q;
    alu_req  = '{start: 1'b0, op: rpnsa_pkg::ALU_ADD};
    unique case (state_q)
      rpnsa_pkg::TOP_IDLE: begin
        if (in_fire) begin
          kind_d = in_ch_i.kind;
          push_d = push_ext;
          if (in_ch_i.kind == rpnsa_pkg::KIND_PUSH) begin
            status_d = rpnsa_pkg::ST_OK;
            apply_d  = 1'b1;
            state_d  = rpnsa_pkg::TOP_DONE;
          end else begin
            status_d = rpnsa_pkg::ST_OK;
            apply_d  = 1'b1;
            state_d  = rpnsa_pkg::TOP_RUN;
            alu_req.start = 1'b1;
            case (in_ch_i.op_char)
              rpnsa_pkg::OP_PLUS:  alu_req.op = rpnsa_pkg::ALU_ADD;
              rpnsa_pkg::OP_MINUS: alu_req.op = rpnsa_pkg::ALU_SUB;
              rpnsa_pkg::OP_TIMES: alu_req.op = rpnsa_pkg::ALU_MUL;
              rpnsa_pkg::OP_DIVIDE: begin
                alu_req.op = rpnsa_pkg::ALU_DIV;
                if (stk_q[0] == '0) begin
                  alu_req.start = 1'b0;
                  status_d      = rpnsa_pkg::ST_DIV0;
                  apply_d       = 1'b0;
                  state_d       = rpnsa_pkg::TOP_DONE;
                end
              end
              default: begin
                alu_req.start = 1'b0;
                status_d      = rpnsa_pkg::ST_BADOP;
                apply_d       = 1'b0;
                state_d       = rpnsa_pkg::TOP_DONE;
              end
            endcase
          end
        end
      end
      rpnsa_pkg::TOP_RUN: begin
        if (alu_done) state_d = rpnsa_pkg::TOP_DONE;
      end
      rpnsa_pkg::TOP_DONE: begin
        if (out_free) state_d = rpnsa_pkg::TOP_IDLE;
      end
      default: state_d = rpnsa_pkg::TOP_IDLE;
    endcase
  end

  // lift on push, drop on a good operate
  always_comb begin
    for (int i = 0; i < STACK_DEPTH; i++) stk_d[i] = stk_q[i];
    if (commit && apply_q) begin
      if (kind_q == rpnsa_pkg::KIND_PUSH) begin
        for (int i = 1; i < STACK_DEPTH; i++) stk_d[i] = stk_q[i-1];
        stk_d[0] = push_q;
      end else begin
        for (int i = 1; i < STACK_DEPTH - 1; i++) stk_d[i] = stk_q[i+1];
        stk_d[STACK_DEPTH-1] = '0;
        stk_d[0]             = alu_res;
      end
    end
  end

  for (genvar j = 0; j < NL; j++) begin : g_lvl
    if (j < STACK_DEPTH) begin : g_have
      if (DATA_WIDTH >= VW) begin : g_cut
        assign lvl_fit[j] = stk_d[j][VW-1:0];
      end else begin : g_zext
        assign lvl_fit[j] = {{(VW-DATA_WIDTH){1'b0}}, stk_d[j]};
      end
    end else begin : g_none
      assign lvl_fit[j] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rpnsa_pkg::TOP_IDLE;
      status_q    <= rpnsa_pkg::ST_OK;
      apply_q     <= 1'b0;
      kind_q      <= rpnsa_pkg::KIND_PUSH;
      out_valid_q <= 1'b0;
      for (int i = 0; i < STACK_DEPTH; i++) stk_q[i] <= '0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      apply_q  <= apply_d;
      kind_q   <= kind_d;
      for (int i = 0; i < STACK_DEPTH; i++) stk_q[i] <= stk_d[i];
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    push_q <= push_d;
    if (commit) begin
      out_status_q <= status_q;
      for (int j = 0; j < NL; j++) out_lvl_q[j] <= lvl_fit[j];
    end
  end

  assign in_ch_i.ready    = in_ready;
  assign out_ch_o.valid   = out_valid_q;
  assign out_ch_o.level_x = out_lvl_q[0];
  assign out_ch_o.level_y = out_lvl_q[1];
  assign out_ch_o.level_z = out_lvl_q[2];
  assign out_ch_o.level_t = out_lvl_q[3];
  assign out_ch_o.status  = out_status_q;

endmodule

>>> hw/rtl/rpnsa_checker.sv
// rpnsa_checker: port-level assertions for rpn_four_level_stack_alu_unit
// depends on rpnsa_pkg; bound to the top level at the end of this file

module rpnsa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          in_kind_i,
  input logic [rpnsa_pkg::OP_W-1:0]     in_op_char_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [rpnsa_pkg::STATUS_W-1:0] out_status_i
);

  logic in_fire;
  logic bad_op;

  assign in_fire = in_valid_i && in_ready_i;
  assign bad_op  = (in_kind_i == rpnsa_pkg::KIND_OPER) &&
                   (in_op_char_i != rpnsa_pkg::OP_PLUS) &&
                   (in_op_char_i != rpnsa_pkg::OP_MINUS) &&
                   (in_op_char_i != rpnsa_pkg::OP_TIMES) &&
                   (in_op_char_i != rpnsa_pkg::OP_DIVIDE);

  // a held result beat keeps its status
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i))
    else $error("result beat dropped or changed while stalled");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_i)
    else $error("input taken again right after an accept");

  // a push shows up with ok status, through the done state, when the output is free
  a_push_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_kind_i == rpnsa_pkg::KIND_PUSH)) ##1 (!out_valid_i || out_ready_i)
    |=> out_valid_i && (out_status_i == rpnsa_pkg::ST_OK))
    else $error("push result missing or not ok");

  // unknown operator reports its error without running the alu
  a_badop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && bad_op) ##1 (!out_valid_i || out_ready_i)
    |=> out_valid_i && (out_status_i == rpnsa_pkg::ST_BADOP))
    else $error("unknown operator not reported");

endmodule

bind rpn_four_level_stack_alu_unit rpnsa_checker u_rpnsa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch_i.valid),
  .in_ready_i  (in_ch_i.ready),
  .in_kind_i   (in_ch_i.kind),
  .in_op_char_i(in_ch_i.op_char),
  .out_valid_i (out_ch_o.valid),
  .out_ready_i (out_ch_o.ready),
  .out_status_i(out_ch_o.status)
);

>>> sim/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking regression of rpn_four_level_stack_alu_unit
// depends on rpnsa_pkg, rpnsa_in_if, rpnsa_out_if and the rtl under hw/rtl

module testbench;

  typedef logic signed [rpnsa_pkg::VALUE_W-1:0] word_t;

  typedef struct packed {
    word_t              x;
    word_t              y;
    word_t              z;
    word_t              t;
    rpnsa_pkg::status_e st;
  } stack_view_t;

  localparam word_t W_MAX         = 32'sh7FFF_FFFF;
  localparam word_t W_MIN         = 32'sh8000_0000;
  localparam int    HOLDOFF_LEN   = 120;
  localparam int    SETTLE_CYCLES = 60;
  localparam int    MAX_PRINTED   = 40;
  localparam int    WATCHDOG_NS   = 4_000_000;

  logic clk;
  logic rst_n;

  rpnsa_in_if  in_ch ();
  rpnsa_out_if out_ch ();

  rpn_four_level_stack_alu_unit dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch)
  );

  // shadow copy of the stack, level 0 is X
  word_t       shadow_stack [rpnsa_pkg::OUT_LEVELS];
  stack_view_t expected_views [$];

  int mismatch_count = 0;
  int beats_checked  = 0;
  int pushes_seen    = 0;
  int arith_ok       = 0;
  int div_zero_hits  = 0;
  int bad_op_hits    = 0;
  bit src_idling     = 1'b0;
  bit sink_idling    = 1'b0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int stall_left     = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #(WATCHDOG_NS);
    $display("timeout with %0d results outstanding", expected_views.size());
    $display("rpn_four_level_stack_alu_unit regression: fail");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic word_t quotient_trunc(input word_t num, input word_t den);
    logic [rpnsa_pkg::VALUE_W-1:0] mag_n;
    logic [rpnsa_pkg::VALUE_W-1:0] mag_d;
    logic [rpnsa_pkg::VALUE_W-1:0] q;
    mag_n = num[rpnsa_pkg::VALUE_W-1] ? -num : num;
    mag_d = den[rpnsa_pkg::VALUE_W-1] ? -den : den;
    q = mag_n / mag_d;
    if (num[rpnsa_pkg::VALUE_W-1] ^ den[rpnsa_pkg::VALUE_W-1]) q = -q;
    return q;
  endfunction

  function automatic stack_view_t apply_to_stack(input logic kind, input word_t value,
                                                 input logic [rpnsa_pkg::OP_W-1:0] op);
    word_t              x;
    word_t              y;
    word_t              r;
    logic               apply;
    rpnsa_pkg::status_e st;
    stack_view_t        view;
    x = shadow_stack[0];
    y = shadow_stack[1];
    r = '0;
    apply = 1'b1;
    st = rpnsa_pkg::ST_OK;
    if (kind == rpnsa_pkg::KIND_PUSH) begin
      for (int i = rpnsa_pkg::OUT_LEVELS - 1; i > 0; i--) shadow_stack[i] = shadow_stack[i-1];
      shadow_stack[0] = value;
      pushes_seen++;
    end else begin
      case (op)
        rpnsa_pkg::OP_PLUS:  r = y + x;
        rpnsa_pkg::OP_MINUS: r = y - x;
        rpnsa_pkg::OP_TIMES: r = y * x;
        rpnsa_pkg::OP_DIVIDE: begin
          if (x == '0) begin
            st = rpnsa_pkg::ST_DIV0;
            apply = 1'b0;
          end else begin
            r = quotient_trunc(y, x);
          end
        end
        default: begin
          st = rpnsa_pkg::ST_BADOP;
          apply = 1'b0;
        end
      endcase
      if (apply) begin
        for (int i = 0; i < rpnsa_pkg::OUT_LEVELS - 1; i++) shadow_stack[i] = shadow_stack[i+1];
        shadow_stack[rpnsa_pkg::OUT_LEVELS-1] = '0;
        shadow_stack[0] = r;
        arith_ok++;
      end else if (st == rpnsa_pkg::ST_DIV0) begin
        div_zero_hits++;
      end else begin
        bad_op_hits++;
      end
    end
    view.x  = shadow_stack[0];
    view.y  = shadow_stack[1];
    view.z  = shadow_stack[2];
    view.t  = shadow_stack[3];
    view.st = st;
    return view;
  endfunction

  // called right after a rising edge; returns right after the accepting edge
  task automatic send_item(input logic kind, input word_t value,
                           input logic [rpnsa_pkg::OP_W-1:0] op);
    if (src_idling && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.push_value <= value;
    in_ch.op_char    <= op;
    do @(posedge clk); while (!in_ch.ready);
    expected_views.push_back(apply_to_stack(kind, value, op));
  endtask

  task automatic idle_source();
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (expected_views.size() != 0);
  endtask

  function automatic word_t pick_value();
    case ($urandom_range(0, 7))
      0, 1, 2: return word_t'(int'($urandom_range(0, 40)) - 20);
      3: begin
        case ($urandom_range(0, 3))
          0: return W_MAX;
          1: return W_MIN;
          2: return -1;
          default: return W_MIN + 1;
        endcase
      end
      4: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [rpnsa_pkg::OP_W-1:0] pick_operator();
    case ($urandom_range(0, 4))
      0: return rpnsa_pkg::OP_PLUS;
      1: return rpnsa_pkg::OP_MINUS;
      2: return rpnsa_pkg::OP_TIMES;
      default: return rpnsa_pkg::OP_DIVIDE;
    endcase
  endfunction

  // mostly pushes followed by a legal operator, the rest raw noise
  task automatic run_random_mix(input int n_items);
    int sent;
    int shape;
    sent = 0;
    while (sent < n_items) begin
      shape = $urandom_range(0, 19);
      if (shape < 13) begin
        repeat ($urandom_range(1, 2)) begin
          send_item(rpnsa_pkg::KIND_PUSH, pick_value(), 8'($urandom));
          sent++;
        end
        send_item(rpnsa_pkg::KIND_OPER, $urandom, pick_operator());
      end else if (shape < 16) begin
        send_item(rpnsa_pkg::KIND_OPER, $urandom, 8'($urandom));
      end else begin
        send_item(1'($urandom), $urandom, 8'($urandom));
      end
      sent++;
    end
  endtask

  task automatic test_reset_state();
    send_item(rpnsa_pkg::KIND_OPER, $urandom, 8'h00);
    send_item(rpnsa_pkg::KIND_OPER, 32'sh0, rpnsa_pkg::OP_PLUS);
  endtask

  task automatic test_stack_lift_and_drop();
    for (int i = 1; i <= 5; i++) send_item(rpnsa_pkg::KIND_PUSH, word_t'(i), 8'hFF);
    send_item(rpnsa_pkg::KIND_OPER, W_MIN, rpnsa_pkg::OP_MINUS);
  endtask

  task automatic test_wraparound();
    send_item(rpnsa_pkg::KIND_PUSH, W_MAX, rpnsa_pkg::OP_PLUS);
    send_item(rpnsa_pkg::KIND_PUSH, 32'sd1, rpnsa_pkg::OP_PLUS);
    send_item(rpnsa_pkg::KIND_OPER, 32'sd0, rpnsa_pkg::OP_PLUS);
    send_item(rpnsa_pkg::KIND_PUSH, 32'sd1, rpnsa_pkg::OP_TIMES);
    send_item(rpnsa_pkg::KIND_OPER, -1, rpnsa_pkg::OP_MINUS);
    send_item(rpnsa_pkg::KIND_PUSH, W_MIN, rpnsa_pkg::OP_DIVIDE);
    send_item(rpnsa_pkg::KIND_PUSH, -1, rpnsa_pkg::OP_MINUS);
    send_item(rpnsa_pkg::KIND_OPER, W_MAX, rpnsa_pkg::OP_TIMES);
    send_item(rpnsa_pkg::KIND_PUSH, -1, rpnsa_pkg::OP_PLUS);
    send_item(rpnsa_pkg::KIND_OPER, 32'sd0, rpnsa_pkg::OP_DIVIDE);
  endtask

  task automatic test_divide_cases();
    send_item(rpnsa_pkg::KIND_PUSH, -32'sd7, rpnsa_pkg::OP_DIVIDE);
    send_item(rpnsa_pkg::KIND_PUSH, 32'sd2, rpnsa_pkg::OP_DIVIDE);
    send_item(rpnsa_pkg::KIND_OPER, 32'sd0, rpnsa_pkg::OP_DIVIDE);
    send_item(rpnsa_pkg::KIND_PUSH, 32'sd0, rpnsa_pkg::OP_DIVIDE);
    send_item(rpnsa_pkg::KIND_OPER, W_MAX, rpnsa_pkg::OP_DIVIDE);
  endtask

  task automatic test_bad_operators();
    send_item(rpnsa_pkg::KIND_OPER, 32'sd0, 8'hFF);
    send_item(rpnsa_pkg::KIND_OPER, -1, 8'h2C);
  endtask

  task automatic test_random_traffic();
    src_idling  = 1'b1;
    sink_idling = 1'b1;
    run_random_mix(400);
  endtask

  // sink stops for a long stretch while items keep coming
  task automatic test_output_holdoff();
    src_idling = 1'b0;
    hold_requests++;
    run_random_mix(30);
    src_idling = 1'b1;
  endtask

  task automatic test_drain_pause();
    run_random_mix(10);
    idle_source();
    wait_drained();
    run_random_mix(10);
  endtask

  task automatic test_full_rate();
    src_idling  = 1'b0;
    sink_idling = 1'b0;
    run_random_mix(80);
  endtask

  // result side: drives ready and checks every accepted beat
  always @(posedge clk) begin
    stack_view_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_views.size() == 0) begin
          report_mismatch($sformatf("beat %0d arrived with nothing expected", beats_checked));
        end else begin
          want = expected_views.pop_front();
          if (out_ch.level_x !== want.x)
            report_mismatch($sformatf("beat %0d level_x %0d want %0d",
                                      beats_checked, out_ch.level_x, want.x));
          if (out_ch.level_y !== want.y)
            report_mismatch($sformatf("beat %0d level_y %0d want %0d",
                                      beats_checked, out_ch.level_y, want.y));
          if (out_ch.level_z !== want.z)
            report_mismatch($sformatf("beat %0d level_z %0d want %0d",
                                      beats_checked, out_ch.level_z, want.z));
          if (out_ch.level_t !== want.t)
            report_mismatch($sformatf("beat %0d level_t %0d want %0d",
                                      beats_checked, out_ch.level_t, want.t));
          if (out_ch.status !== want.st)
            report_mismatch($sformatf("beat %0d status %0d want %0d",
                                      beats_checked, out_ch.status, want.st));
        end
        beats_checked++;
      end
      if (hold_requests != hold_served) begin
        hold_served++;
        hold_left = HOLDOFF_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (sink_idling && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    for (int i = 0; i < rpnsa_pkg::OUT_LEVELS; i++) shadow_stack[i] = '0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.kind       <= rpnsa_pkg::KIND_PUSH;
    in_ch.push_value <= '0;
    in_ch.op_char    <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_stack_lift_and_drop();
    test_wraparound();
    test_divide_cases();
    test_bad_operators();
    test_random_traffic();
    test_output_holdoff();
    test_drain_pause();
    test_full_rate();

    idle_source();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d pushes, %0d completed operations, %0d divides by zero,",
             pushes_seen, arith_ok, div_zero_hits);
    $display("%0d invalid operators; %0d result beats checked, %0d mismatches",
             bad_op_hits, beats_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("rpn_four_level_stack_alu_unit regression: pass");
    end else begin
      $display("rpn_four_level_stack_alu_unit regression: fail");
    end
    $finish;
  end

endmodule
